>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is held
`define SRPMC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication form of the same
`define SRPMC_ASSERT_IMP(label, ante, cons, msg) \
  `SRPMC_ASSERT(label, (ante) |-> (cons), msg)

// next-cycle implication form
`define SRPMC_ASSERT_NXT(label, ante, cons, msg) \
  `SRPMC_ASSERT(label, (ante) |=> (cons), msg)

`endif

>>> rtl/srpmc_pkg.sv
// shared types and constants of the square ring pixel mass counter
`timescale 1ns / 1ps
`default_nettype none
package srpmc_pkg;

  localparam int MAX_SIDE   = 128;
  localparam int RING_DEPTH = (MAX_SIDE - 1) / 2 + 1;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int RING_W     = 9;
  localparam int SUM_W      = 14;
  localparam int SIZE_W     = 8;
  localparam int COORD_W    = 7;
  localparam int PIX_W      = 16;
  localparam int HALF_W     = 6;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [RING_W-1:0] RING_MAX = {RING_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = CFG_IDX_W'(1);

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_SIDE);

  // one classified item handed from the front to the back
  typedef struct packed {
    logic               count_en;
    logic [RING_AW-1:0] ring;
    logic               last;
    logic [HALF_W-1:0]  max_half;
  } queue_entry_t;

endpackage
`default_nettype wire

>>> rtl/srpmc_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module srpmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/srpmc_front.sv
// front: size registers, ring classification of each incoming pixel
`timescale 1ns / 1ps
`default_nettype none
module srpmc_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [srpmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [srpmc_pkg::SIZE_W-1:0]      cfg_data,
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  input  wire logic [srpmc_pkg::IN_DATA_W-1:0]   in_tdata,
  input  wire logic                              in_tlast,
  output      logic                              push_valid,
  input  wire logic                              push_ready,
  output      srpmc_pkg::queue_entry_t           push_entry
);
  import srpmc_pkg::*;

  logic [SIZE_W-1:0]  width_r, height_r;
  logic [SIZE_W-1:0]  side_min, side_clamp, side_m1;
  logic [HALF_W-1:0]  max_half;
  logic [COORD_W-1:0] mh_ext, col, row, dc, dr, ring_dist;
  logic [PIX_W-1:0]   pix;
  logic               active;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_RESET;
      height_r <= SIZE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_IDX_WIDTH) begin
        width_r <= cfg_data;
      end
      if (cfg_index == CFG_IDX_HEIGHT) begin
        height_r <= cfg_data;
      end
    end
  end

  always_comb begin
    side_min = (width_r < height_r) ? width_r : height_r;
    priority if (side_min == '0) begin
      side_clamp = SIZE_W'(1);
    end else if (side_min > SIZE_W'(MAX_SIDE)) begin
      side_clamp = SIZE_W'(MAX_SIDE);
    end else begin
      side_clamp = side_min;
    end
    side_m1  = side_clamp - SIZE_W'(1);
    max_half = side_m1[HALF_W:1];
    mh_ext   = COORD_W'(max_half);

    pix    = in_tdata[PIX_W-1:0];
    col    = in_tdata[PIX_W +: COORD_W];
    row    = in_tdata[PIX_W+COORD_W +: COORD_W];
    active = !pix[PIX_W-1] && (pix != '0);

    dc        = (col >= mh_ext) ? col - mh_ext : mh_ext - col;
    dr        = (row >= mh_ext) ? row - mh_ext : mh_ext - row;
    ring_dist = (dc > dr) ? dc : dr;
  end

  assign in_tready  = push_ready;
  assign push_valid = in_tvalid;

  always_comb begin
    push_entry.count_en = active && (ring_dist <= mh_ext);
    push_entry.ring     = ring_dist[RING_AW-1:0];
    push_entry.last     = in_tlast;
    push_entry.max_half = max_half;
  end

endmodule
`default_nettype wire

>>> rtl/srpmc_queue.sv
// short queue of classified items between front and back
`timescale 1ns / 1ps
`default_nettype none
module srpmc_queue (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push_valid,
  output      logic                    push_ready,
  input  wire srpmc_pkg::queue_entry_t push_entry,
  output      logic                    pop_valid,
  input  wire logic                    pop,
  output      srpmc_pkg::queue_entry_t pop_entry
);
  import srpmc_pkg::*;

  queue_entry_t        slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr_r, rptr_r;
  logic [QUEUE_AW:0]   count_r;
  logic                do_push, do_pop;

  assign push_ready = (count_r != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = slot_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rptr_r <= rptr_r + QUEUE_AW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + (QUEUE_AW+1)'(1);
        2'b01:   count_r <= count_r - (QUEUE_AW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/srpmc_back.sv
// back: ring counter updates and the cumulative emission walk
`timescale 1ns / 1ps
`default_nettype none
module srpmc_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              pop_valid,
  output      logic                              pop,
  input  wire srpmc_pkg::queue_entry_t           pop_entry,
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  output      logic [srpmc_pkg::OUT_DATA_W-1:0]  out_tdata,
  output      logic                              out_tlast
);
  import srpmc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_EMIT_RD,
    ST_EMIT_ACC
  } state_t;

  state_t              state_r;
  queue_entry_t        ent_r;
  logic [RING_AW-1:0]  lvl_r;
  logic [SUM_W-1:0]    sum_r;
  logic [RING_DEPTH-1:0] ring_valid_r;
  logic                out_valid_r, out_last_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                ram_we, ram_re;
  logic [RING_AW-1:0]  ram_waddr, ram_raddr;
  logic [RING_W-1:0]   ram_wdata, ram_rdata, cur_cnt, lvl_cnt;
  logic [SUM_W:0]      sum_wide;
  logic [SUM_W-1:0]    sum_sat, sum_show;
  logic                out_free;
  logic                out_load;

  srpmc_ram #(
    .WIDTH (RING_W),
    .DEPTH (RING_DEPTH)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || out_tready;
  assign out_load = (state_r == ST_EMIT_ACC) && out_free;

  always_comb begin
    pop       = (state_r == ST_IDLE) && pop_valid;
    ram_re    = 1'b0;
    ram_raddr = pop_entry.ring;
    if (state_r == ST_IDLE) begin
      ram_re = pop_valid && pop_entry.count_en;
    end else if (state_r == ST_EMIT_RD) begin
      ram_re    = 1'b1;
      ram_raddr = lvl_r;
    end

    // an entry never written since the last clear reads as zero
    cur_cnt   = ring_valid_r[ent_r.ring] ? ram_rdata : '0;
    ram_we    = (state_r == ST_UPD);
    ram_waddr = ent_r.ring;
    ram_wdata = (cur_cnt == RING_MAX) ? RING_MAX : cur_cnt + RING_W'(1);

    lvl_cnt  = ring_valid_r[lvl_r] ? ram_rdata : '0;
    sum_wide = {1'b0, sum_r} + (SUM_W+1)'(lvl_cnt);
    sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    sum_show = (lvl_r == '0) ? '0 : sum_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ring_valid_r <= '0;
      out_valid_r  <= 1'b0;
      lvl_r        <= '0;
      sum_r        <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (pop_valid) begin
            ent_r <= pop_entry;
            lvl_r <= '0;
            sum_r <= '0;
            if (pop_entry.count_en) begin
              state_r <= ST_UPD;
            end else if (pop_entry.last) begin
              state_r <= ST_EMIT_RD;
            end
          end
        end
        ST_UPD: begin
          ring_valid_r[ent_r.ring] <= 1'b1;
          state_r <= ent_r.last ? ST_EMIT_RD : ST_IDLE;
        end
        ST_EMIT_RD: begin
          state_r <= ST_EMIT_ACC;
        end
        ST_EMIT_ACC: begin
          if (out_free) begin
            out_data_r  <= {(OUT_DATA_W-SUM_W-HALF_W)'(0), sum_show, HALF_W'(lvl_r)};
            out_last_r  <= (HALF_W'(lvl_r) == ent_r.max_half);
            sum_r       <= sum_sat;
            if (HALF_W'(lvl_r) == ent_r.max_half) begin
              ring_valid_r <= '0;
              state_r      <= ST_IDLE;
            end else begin
              lvl_r   <= lvl_r + RING_AW'(1);
              state_r <= ST_EMIT_RD;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

>>> rtl/square_ring_pixel_mass_count.sv
// top level of the square ring pixel mass counter
`timescale 1ns / 1ps
`default_nettype none
// Counts active pixels (signed value above zero) of an image by square ring
// around the centre of the largest odd square that fits the image, max_half =
// (min(width, height) - 1) / 2, centre at column = row = max_half; pixels
// outside the square are dropped. The beat flagged with in_tlast closes the
// image: after counting it the block sends max_half + 1 beats, one per half
// size L from 0 up, carrying the saturating count of active pixels within
// Chebyshev distance L (always zero for L = 0) and out_tlast on the largest L;
// the ring counters are then cleared. Timing: pixels enter through a
// four-beat queue, so in_tready stays high while the queue has room. The back
// end does a read-modify-write of the ring counter ram (single registered read
// port) for an active pixel inside the square and takes any other pixel alone
// in the idle state; closing an image adds a read and an accumulate state per
// ring, stalled while out_tready is low. The user must write the size registers
// via the cfg port only while the block is idle; the block does not enforce it.
module square_ring_pixel_mass_count (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // size register writes: index 0 width, index 1 height
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [srpmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [srpmc_pkg::SIZE_W-1:0]      cfg_data,
  // pixel beats
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  // pixel_value[15:0], column[22:16], row[29:23], zero [31:30]
  input  wire logic [srpmc_pkg::IN_DATA_W-1:0]   in_tdata,
  input  wire logic                              in_tlast,   // end of image
  // mass-radius beats
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  // half_size[5:0], cumulative_count[19:6], zero [23:20]
  output      logic [srpmc_pkg::OUT_DATA_W-1:0]  out_tdata,
  output      logic                              out_tlast   // largest half size
);
  import srpmc_pkg::*;

  // classified items between front and back
  queue_entry_t push_entry, pop_entry;
  logic         push_valid, push_ready, pop_valid, pop;

  // front classifies each pixel into its ring against the current sizes
  srpmc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  // queue lets the front keep taking pixels while the back is busy
  srpmc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_entry  (pop_entry)
  );

  // back owns the ring counters and the emission walk
  srpmc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

>>> rtl/srpmc_checker.sv
// port-level checker of the square ring pixel mass counter, with its bind
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module srpmc_checker (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic [srpmc_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  wire logic                              out_tlast
);
  import srpmc_pkg::*;

  `SRPMC_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "out beat dropped while stalled")
  `SRPMC_ASSERT_NXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tlast), "out beat changed while stalled")
  `SRPMC_ASSERT_IMP(a_centre_zero, out_tvalid && (out_tdata[HALF_W-1:0] == '0), out_tdata[HALF_W +: SUM_W] == '0, "count for half size zero must be zero")
  `SRPMC_ASSERT_IMP(a_top_is_last, out_tvalid && !out_tlast, out_tdata[HALF_W-1:0] != HALF_W'(RING_DEPTH - 1), "largest ring not flagged last")

endmodule

bind square_ring_pixel_mass_count srpmc_checker u_srpmc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire
